// ===== rtl/bfse_pkg.sv =====
// Shared types and codes for the bounded FIFO with occupancy events.
// No dependencies; imported by bfse_ctrl and the top level.
package bfse_pkg;

  localparam int unsigned CountOutWidth = 9;
  localparam int unsigned PortHandleWidth = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_PULL_REFUSED = 2'd1,
    ST_PUSH_REFUSED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OCC_EMPTY    = 2'd0,
    OCC_CONTENTS = 2'd1,
    OCC_FULL     = 2'd2
  } occ_e;

  typedef struct packed {
    status_e                  status;
    logic [CountOutWidth-1:0] entry_count;
    logic                     state_changed;
    occ_e                     new_state;
    occ_e                     prior_state;
    logic                     pulled;
  } meta_t;

endpackage

// ===== rtl/bfse_slot_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module bfse_slot_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bfse_ctrl.sv =====
// Queue control: pointers, entry count, limit check and occupancy states.
// Depends on bfse_pkg; drives the slot memory ports.
module bfse_ctrl
  import bfse_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  op_e                        op_i,
  input  logic [PortHandleWidth-1:0] frame_in_i,
  input  logic [CountOutWidth-1:0]   capacity_limit_i,
  output logic                       mem_we_o,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr_o,
  output logic [HANDLE_WIDTH-1:0]    mem_wdata_o,
  output logic                       mem_re_o,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr_o,
  output meta_t                      meta_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CountOutWidth) ? CW : CountOutWidth;
  localparam int unsigned XW = (HANDLE_WIDTH > PortHandleWidth) ? HANDLE_WIDTH
                                                                : PortHandleWidth;

  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;

  logic [LW-1:0] limit;
  logic [LW-1:0] cap_ext;
  logic [LW-1:0] old_ext;
  logic [LW-1:0] new_ext;
  logic [XW-1:0] frame_ext;
  logic          old_full;
  logic          new_full;
  logic          push_ok;
  logic          pull_ok;
  occ_e          old_occ;
  occ_e          new_occ;

  always_comb begin
    cap_ext = LW'(capacity_limit_i);
    if (cap_ext == '0 || cap_ext > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = cap_ext;
    end
    old_ext  = LW'(count_q);
    old_full = (old_ext >= limit);
    push_ok  = (op_i == OP_PUSH) && !old_full;
    pull_ok  = (op_i == OP_PULL) && (count_q != '0);

    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (fire_i && push_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      count_d  = count_q + CW'(1);
    end else if (fire_i && pull_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      count_d  = count_q - CW'(1);
    end

    new_ext  = LW'(count_d);
    new_full = (new_ext >= limit);

    if (count_q == '0) begin
      old_occ = OCC_EMPTY;
    end else if (old_full) begin
      old_occ = OCC_FULL;
    end else begin
      old_occ = OCC_CONTENTS;
    end
    if (count_d == '0) begin
      new_occ = OCC_EMPTY;
    end else if (new_full) begin
      new_occ = OCC_FULL;
    end else begin
      new_occ = OCC_CONTENTS;
    end

    if (op_i == OP_PUSH) begin
      meta_o.status = push_ok ? ST_OK : ST_PUSH_REFUSED;
    end else begin
      meta_o.status = pull_ok ? ST_OK : ST_PULL_REFUSED;
    end
    meta_o.entry_count   = new_ext[CountOutWidth-1:0];
    meta_o.state_changed = (new_occ != old_occ);
    meta_o.new_state     = new_occ;
    meta_o.prior_state   = old_occ;
    meta_o.pulled        = pull_ok;

    frame_ext   = XW'(frame_in_i);
    mem_we_o    = fire_i && push_ok;
    mem_waddr_o = wr_ptr_q;
    mem_wdata_o = frame_ext[HANDLE_WIDTH-1:0];
    mem_re_o    = fire_i && pull_ok;
    mem_raddr_o = rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/bounded_fifo_with_state_events_top.sv =====
// Top level of the bounded FIFO with occupancy events.
// Depends on bfse_pkg, bfse_ctrl and bfse_slot_mem.
//
// Channels: a request channel (in_valid_i/in_ready_o, op_i, frame_in_i) that
// carries push or pull transactions, a response channel (out_valid_o/
// out_ready_i) with one result per request, and a configuration channel
// (cfg_valid_i/cfg_ready_o, capacity_limit_i) that sets the entry limit.
// The configuration channel is always ready; write it only while idle.
// Pointers and count update at the accepting edge; a pull reads the slot
// memory over its registered read port into the read stage (read data and
// s1 metadata), and the result is then loaded into the output register
// that drives out_valid_o.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the single read and single write port of the slot memory.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; then in_ready_o drops until the output drains.
// Reset clears pointers, count, limit and valid flags; slot contents stay
// undefined until pushed, and no clearing pass is needed.
module bounded_fifo_with_state_events_top
  import bfse_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CountOutWidth-1:0]   capacity_limit_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [PortHandleWidth-1:0] frame_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [PortHandleWidth-1:0] frame_out_o,
  output logic [CountOutWidth-1:0]   entry_count_o,
  output logic                       state_changed_o,
  output logic [1:0]                 new_state_o,
  output logic [1:0]                 prior_state_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned XW = (HANDLE_WIDTH > PortHandleWidth) ? HANDLE_WIDTH
                                                                : PortHandleWidth;

  logic [CountOutWidth-1:0] cap_q;
  logic                     s1_valid_q;
  meta_t                    s1_meta_q;
  meta_t                    meta;
  logic                     out_valid_q;
  meta_t                    out_meta_q;
  logic [PortHandleWidth-1:0] out_frame_q;
  logic                     fire;
  logic                     out_load;
  logic                     mem_we;
  logic [PW-1:0]            mem_waddr;
  logic [HANDLE_WIDTH-1:0]  mem_wdata;
  logic                     mem_re;
  logic [PW-1:0]            mem_raddr;
  logic [HANDLE_WIDTH-1:0]  mem_rdata;
  logic [XW-1:0]            rdata_ext;

  assign cfg_ready_o = 1'b1;
  assign out_load    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || out_load;
  assign fire        = in_valid_i && in_ready_o;
  assign rdata_ext   = XW'(mem_rdata);

  bfse_ctrl #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .op_i             (op_e'(op_i)),
    .frame_in_i       (frame_in_i),
    .capacity_limit_i (cap_q),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .meta_o           (meta)
  );

  bfse_slot_mem #(
    .DEPTH (DEPTH),
    .WIDTH (HANDLE_WIDTH)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= capacity_limit_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= fire;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_meta_q <= meta;
    end
    if (out_load) begin
      out_meta_q  <= s1_meta_q;
      out_frame_q <= s1_meta_q.pulled ? rdata_ext[PortHandleWidth-1:0] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_meta_q.status;
  assign frame_out_o     = out_frame_q;
  assign entry_count_o   = out_meta_q.entry_count;
  assign state_changed_o = out_meta_q.state_changed;
  assign new_state_o     = out_meta_q.new_state;
  assign prior_state_o   = out_meta_q.prior_state;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for bounded_fifo_with_state_events_top.
// Holds its own FIFO predictor and drives the request, response and config channels.
// Depends on bfse_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import bfse_pkg::*;

  localparam int unsigned SlotCount = 256;
  localparam int unsigned LongStall = 300;
  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    op_e         op;
    logic [31:0] frame;
  } fifo_request_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] frame;
    logic [8:0]  count;
    logic        changed;
    occ_e        new_occ;
    occ_e        old_occ;
  } fifo_response_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  capacity_limit_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = 1'b0;
  logic [31:0] frame_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] frame_out_o;
  logic [8:0]  entry_count_o;
  logic        state_changed_o;
  logic [1:0]  new_state_o;
  logic [1:0]  prior_state_o;

  fifo_request_t  fifo_requests[$];
  fifo_response_t due_responses[$];

  logic [31:0] slot_copy [SlotCount];
  logic [7:0]  head_ptr = '0;
  logic [7:0]  tail_ptr = '0;
  logic [8:0]  held_entries = '0;
  logic [8:0]  limit_copy = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  logic        stall_req = 1'b0;
  logic        stall_ack = 1'b0;

  bounded_fifo_with_state_events_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .capacity_limit_i(capacity_limit_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .frame_in_i      (frame_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_out_o     (frame_out_o),
    .entry_count_o   (entry_count_o),
    .state_changed_o (state_changed_o),
    .new_state_o     (new_state_o),
    .prior_state_o   (prior_state_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [8:0] active_limit();
    if (limit_copy == 0 || limit_copy > SlotCount) return 9'(SlotCount);
    return limit_copy;
  endfunction

  function automatic occ_e occupancy_of(logic [8:0] count);
    if (count == 0) return OCC_EMPTY;
    if (count >= active_limit()) return OCC_FULL;
    return OCC_CONTENTS;
  endfunction

  function automatic fifo_response_t predict_response(op_e op, logic [31:0] frame);
    fifo_response_t r;
    r.old_occ = occupancy_of(held_entries);
    r.status  = ST_OK;
    r.frame   = '0;
    if (op == OP_PUSH) begin
      if (held_entries >= active_limit()) begin
        r.status = ST_PUSH_REFUSED;
      end else begin
        slot_copy[tail_ptr] = frame;
        tail_ptr = tail_ptr + 8'd1;
        held_entries = held_entries + 9'd1;
      end
    end else begin
      if (held_entries == 0) begin
        r.status = ST_PULL_REFUSED;
      end else begin
        r.frame = slot_copy[head_ptr];
        head_ptr = head_ptr + 8'd1;
        held_entries = held_entries - 9'd1;
      end
    end
    r.new_occ = occupancy_of(held_entries);
    r.count   = held_entries;
    r.changed = (r.new_occ != r.old_occ);
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    fifo_request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= OP_PUSH;
      frame_in_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (fifo_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = fifo_requests.pop_front();
        in_valid_i <= 1'b1;
        op_i <= req.op;
        frame_in_i <= req.frame;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      stall_ack <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      stall_left <= LongStall;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    fifo_response_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_responses.size() == 0) begin
          note_mismatch("unexpected transaction", '0, {30'd0, status_o});
        end else begin
          want = due_responses.pop_front();
          check_field("status", want.status, status_o);
          check_field("frame_out", want.frame, frame_out_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("state_changed", want.changed, state_changed_o);
          check_field("new_state", want.new_occ, new_state_o);
          check_field("prior_state", want.old_occ, prior_state_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        due_responses.push_back(predict_response(op_e'(op_i), frame_in_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_request(op_e op, logic [31:0] frame);
    fifo_requests.push_back('{op: op, frame: frame});
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (fifo_requests.size() != 0 || in_valid_i || due_responses.size() != 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limit(logic [8:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    capacity_limit_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_copy = value;
    @(negedge clk_i);
  endtask

  task automatic add_random(int unsigned total, int unsigned bound);
    int unsigned made;
    int unsigned run;
    int unsigned pick;
    made = 0;
    while (made < total) begin
      pick = $urandom_range(9);
      run = (pick < 8) ? $urandom_range(1, bound + 2) : 8;
      if (run > total - made) run = total - made;
      repeat (run) begin
        if (pick < 4) add_request(OP_PUSH, $urandom);
        else if (pick < 8) add_request(OP_PULL, $urandom);
        else add_request(op_e'($urandom_range(1)), $urandom);
      end
      made += run;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 50;

    write_limit(9'd2);
    add_request(OP_PULL, 32'h1234_5678);
    add_request(OP_PUSH, 32'h0000_0000);
    add_request(OP_PUSH, 32'hFFFF_FFFF);
    add_request(OP_PUSH, 32'hA5A5_A5A5);
    add_request(OP_PULL, 32'hFFFF_FFFF);
    add_request(OP_PULL, 32'h0000_0000);
    add_request(OP_PULL, 32'h0000_0000);
    wait_drained();

    write_limit(9'd1);
    add_request(OP_PUSH, 32'h5A5A_5A5A);
    add_request(OP_PUSH, 32'h0F0F_0F0F);
    add_request(OP_PULL, 32'h0);
    wait_drained();

    write_limit(9'd0);
    repeat (6) add_request(OP_PUSH, $urandom);
    wait_drained();
    // lower the limit below the held count
    write_limit(9'd3);
    add_request(OP_PUSH, $urandom);
    repeat (4) add_request(OP_PULL, $urandom);
    wait_drained();

    stall_req <= ~stall_req;
    add_random(250, 3);
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 19;
    write_limit(9'd0);
    repeat (260) add_request(OP_PUSH, $urandom);
    repeat (260) add_request(OP_PULL, $urandom);
    wait_drained();

    write_limit(9'd17);
    add_random(250, 17);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(9'd256);
    add_random(300, 256);
    wait_drained();

    write_limit(9'd511);
    add_random(250, 40);
    wait_drained();

    write_limit(9'd128);
    add_random(200, 128);
    wait_drained();

    write_limit(9'd1);
    add_random(100, 1);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfse_pkg.sv
rtl/bfse_slot_mem.sv
rtl/bfse_ctrl.sv
rtl/bounded_fifo_with_state_events_top.sv
sim/tb.sv
